/* rtl/zrle_pkg.sv */
// ----------------------------------------------------------------------------
// zrle_pkg: shared types and constants of the zero run-length encoder
// Byte select codes, run header constant, and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package zrle_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 8;

  localparam logic [1:0] SEL_PRE  = 2'd0;
  localparam logic [1:0] SEL_HDR  = 2'd1;
  localparam logic [1:0] SEL_RAM  = 2'd2;
  localparam logic [1:0] SEL_POST = 2'd3;

  // header of a run of two zeros: 1 - 2 as a byte
  localparam logic [BYTE_W-1:0] RUN2_HDR = 8'hFF;

  typedef struct packed {
    logic              plan_load;
    logic              byte_valid;
    logic [1:0]        byte_sel;
    logic              byte_last;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
  } zrle_cmd_t;

  typedef struct packed {
    logic              pre_en;
    logic              post_en;
    logic [CNT_W-1:0]  lit_n;
    logic              byte_ready;
  } zrle_sts_t;

endpackage

/* rtl/zrle_if.sv */
// ----------------------------------------------------------------------------
// zrle_if: channel interfaces of the zero run-length encoder
// Input byte channel and packed code group channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface zrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       block_last;

  modport source (output valid, raw_byte, block_last, input ready);
  modport sink   (input valid, raw_byte, block_last, output ready);
endinterface

interface zrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte0;
  logic [7:0] code_byte1;
  logic [7:0] code_byte2;
  logic [7:0] code_byte3;
  logic [2:0] byte_count;
  logic       group_last;
  logic       block_end;

  modport source (output valid, code_byte0, code_byte1, code_byte2, code_byte3,
                  byte_count, group_last, block_end, input ready);
  modport sink   (input valid, code_byte0, code_byte1, code_byte2, code_byte3,
                  byte_count, group_last, block_end, output ready);
endinterface

/* rtl/zero_run_length_encoder_unit.sv */
// Flow: an item is taken into the plan registers, then evaluated, then its code bytes go to the
//   packer one per cycle while it is ready; a group leaves through the packer's output register.
// The next item is taken only once the controller is back in idle, after the last code byte of
//   the item, also for an item that emits nothing; output stalls hold the flow.
// Reset: synchronous, active low; clears packet state and handshakes. Literal store
//   contents stay undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
// zero_run_length_encoder_unit: zero run-length encoder, top level
// Codes a byte stream into literal and zero-run packets, packed four code
// bytes to an output group.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_unit #(
  parameter int MAX_LITERAL  = 128,
  parameter int MAX_ZERO_RUN = 129
) (
  input  logic        clk,
  input  logic        rst_n,
  zrle_in_if.sink     in_ch,
  zrle_out_if.source  out_ch
);

  zrle_pkg::zrle_cmd_t cmd;
  zrle_pkg::zrle_sts_t sts;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  zrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zrle_dp #(
    .MAX_LITERAL  (MAX_LITERAL),
    .MAX_ZERO_RUN (MAX_ZERO_RUN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw_byte   (in_ch.raw_byte),
    .block_last (in_ch.block_last),
    .cmd        (cmd),
    .sts        (sts),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_full_groups: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.group_last) |-> (out_ch.byte_count == 3'd4))
    else $error("non-final group not full");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.block_end) |-> out_ch.group_last)
    else $error("block end on a non-final group");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.byte_count != 3'd0) && (out_ch.byte_count <= 3'd4)))
    else $error("group byte count out of range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.plan_load |=> (!in_ready && !cmd.byte_valid))
    else $error("intake or emit in the cycle after an item is taken");
`endif

endmodule

/* rtl/zrle_ram.sv */
// ----------------------------------------------------------------------------
// zrle_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module zrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/zrle_packer.sv */
// ----------------------------------------------------------------------------
// zrle_packer: packs code bytes four to a group
// Takes one code byte per cycle while not stalled, closes a group when
// full or on the last byte of an item, and holds it in the output register.
// ----------------------------------------------------------------------------
module zrle_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  input  logic                 byte_last,
  input  logic                 blk_last,
  output logic                 byte_ready,
  zrle_out_if.source           out_ch
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] grp_r [4];
  logic [7:0] asm   [4];
  logic [7:0] code_r [4];
  logic [7:0] code_nxt [4];
  logic [2:0] count_r;
  logic       glast_r;
  logic       bend_r;
  logic       out_valid_r, out_valid_nxt;
  logic       take;
  logic       push;

  assign byte_ready = !out_valid_r || out_ch.ready;
  assign take       = byte_valid && byte_ready;
  assign push       = take && ((cnt_r == 2'd3) || byte_last);

  always_comb begin
    asm = grp_r;
    asm[cnt_r] = byte_data;
    for (int k = 0; k < 4; k++) begin
      code_nxt[k] = (2'(k) <= cnt_r) ? asm[k] : 8'd0;
    end
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = push ? 2'd0 : cnt_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grp_r <= asm;
    end
    if (push) begin
      code_r  <= code_nxt;
      count_r <= {1'b0, cnt_r} + 3'd1;
      glast_r <= byte_last;
      bend_r  <= byte_last && blk_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_byte0 = code_r[0];
  assign out_ch.code_byte1 = code_r[1];
  assign out_ch.code_byte2 = code_r[2];
  assign out_ch.code_byte3 = code_r[3];
  assign out_ch.byte_count = count_r;
  assign out_ch.group_last = glast_r;
  assign out_ch.block_end  = bend_r;

endmodule

/* rtl/zrle_dp.sv */
// ----------------------------------------------------------------------------
// zrle_dp: datapath of the zero run-length encoder
// Packet state, per-item emit plan, literal store, code byte select and
// group packer.
// ----------------------------------------------------------------------------
module zrle_dp #(
  parameter int MAX_LITERAL  = 128,
  parameter int MAX_ZERO_RUN = 129
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        raw_byte,
  input  logic              block_last,
  input  zrle_pkg::zrle_cmd_t cmd,
  output zrle_pkg::zrle_sts_t sts,
  zrle_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_LITERAL);
  localparam int LW = $clog2(MAX_LITERAL + 1);
  localparam int ZW = $clog2(MAX_ZERO_RUN + 1);

  logic [LW-1:0] len_r, len_nxt;
  logic          pwz_r, pwz_nxt;
  logic [ZW-1:0] zrl_r, zrl_nxt;

  logic          pre_en_r, pre_en_nxt;
  logic [7:0]    pre_val_r, pre_val_nxt;
  logic [LW-1:0] lit_n_r, lit_n_nxt;
  logic          post_en_r, post_en_nxt;
  logic          last_r;

  logic          b_zero;
  logic          run_open;
  logic [ZW-1:0] zrl_inc;
  logic [LW-1:0] len_inc;
  logic          drop_zero;
  logic          store_we;
  logic [7:0]    rdata;
  logic [7:0]    byte_data;

  assign b_zero    = (raw_byte == 8'd0);
  assign run_open  = (zrl_r != '0);
  assign zrl_inc   = zrl_r + ZW'(1);
  assign len_inc   = len_r + LW'(1);
  assign drop_zero = !run_open && b_zero && pwz_r && (len_r != '0);
  assign store_we  = cmd.plan_load && !(run_open && b_zero) && !drop_zero;

  always_comb begin
    pre_en_nxt  = 1'b0;
    pre_val_nxt = 8'd1 - 8'(zrl_r);
    lit_n_nxt   = '0;
    post_en_nxt = 1'b0;
    len_nxt     = len_r;
    pwz_nxt     = pwz_r;
    zrl_nxt     = zrl_r;
    if (run_open && b_zero) begin
      pre_en_nxt  = (zrl_inc >= ZW'(MAX_ZERO_RUN)) || block_last;
      pre_val_nxt = 8'd1 - 8'(zrl_inc);
      zrl_nxt     = pre_en_nxt ? '0 : zrl_inc;
    end else if (run_open) begin
      pre_en_nxt = 1'b1;
      zrl_nxt    = '0;
      pwz_nxt    = 1'b0;
      if (block_last) begin
        lit_n_nxt = LW'(1);
        len_nxt   = '0;
      end else begin
        len_nxt = LW'(1);
      end
    end else if (drop_zero) begin
      lit_n_nxt   = len_r - LW'(1);
      len_nxt     = '0;
      pwz_nxt     = 1'b0;
      post_en_nxt = (MAX_ZERO_RUN <= 2) || block_last;
      zrl_nxt     = post_en_nxt ? '0 : ZW'(2);
    end else if ((len_inc >= LW'(MAX_LITERAL)) || block_last) begin
      lit_n_nxt = len_inc;
      len_nxt   = '0;
      pwz_nxt   = 1'b0;
    end else begin
      len_nxt = len_inc;
      pwz_nxt = b_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      pwz_r     <= 1'b0;
      zrl_r     <= '0;
      pre_en_r  <= 1'b0;
      lit_n_r   <= '0;
      post_en_r <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.plan_load) begin
      len_r     <= len_nxt;
      pwz_r     <= pwz_nxt;
      zrl_r     <= zrl_nxt;
      pre_en_r  <= pre_en_nxt;
      lit_n_r   <= lit_n_nxt;
      post_en_r <= post_en_nxt;
      last_r    <= block_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan_load) begin
      pre_val_r <= pre_val_nxt;
    end
  end

  zrle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LITERAL)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(len_r)),
    .wdata (raw_byte),
    .re    (cmd.rd_en),
    .raddr (AW'(cmd.rd_idx)),
    .rdata (rdata)
  );

  always_comb begin
    unique case (cmd.byte_sel)
      zrle_pkg::SEL_PRE:  byte_data = pre_val_r;
      zrle_pkg::SEL_HDR:  byte_data = 8'(lit_n_r - LW'(1));
      zrle_pkg::SEL_RAM:  byte_data = rdata;
      zrle_pkg::SEL_POST: byte_data = zrle_pkg::RUN2_HDR;
      default:            byte_data = rdata;
    endcase
  end

  zrle_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (cmd.byte_valid),
    .byte_data  (byte_data),
    .byte_last  (cmd.byte_last),
    .blk_last   (last_r),
    .byte_ready (sts.byte_ready),
    .out_ch     (out_ch)
  );

  assign sts.pre_en  = pre_en_r;
  assign sts.post_en = post_en_r;
  assign sts.lit_n   = zrle_pkg::CNT_W'(lit_n_r);

endmodule

/* rtl/zrle_ctrl.sv */
// ----------------------------------------------------------------------------
// zrle_ctrl: controller of the zero run-length encoder
// Takes one item, then steps through run header, literal header, literal
// bytes and trailing run header, one code byte per cycle while the packer is ready.
// ----------------------------------------------------------------------------
module zrle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  zrle_pkg::zrle_sts_t sts,
  output zrle_pkg::zrle_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_LHDR  = 3'd3;
  localparam logic [2:0] S_LDATA = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [zrle_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [zrle_pkg::CNT_W-1:0] idx_inc;
  logic                       idx_last;
  logic [2:0]                 after_pre;
  logic [2:0]                 after_lit;

  assign idx_inc   = idx_r + 8'd1;
  assign idx_last  = (idx_inc == sts.lit_n);
  assign after_lit = sts.post_en ? S_POST : S_IDLE;
  assign after_pre = (sts.lit_n != '0) ? S_LHDR : after_lit;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_ready       = (state_r == S_IDLE);
    cmd            = '0;
    cmd.plan_load  = in_valid && in_ready;
    cmd.rd_idx     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.plan_load) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = sts.pre_en ? S_PRE : after_pre;
      end
      S_PRE: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_sel   = zrle_pkg::SEL_PRE;
        cmd.byte_last  = (sts.lit_n == '0) && !sts.post_en;
        if (sts.byte_ready) begin
          state_nxt = after_pre;
        end
      end
      S_LHDR: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_sel   = zrle_pkg::SEL_HDR;
        if (sts.byte_ready) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = '0;
          idx_nxt    = '0;
          state_nxt  = S_LDATA;
        end
      end
      S_LDATA: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_sel   = zrle_pkg::SEL_RAM;
        cmd.byte_last  = idx_last && !sts.post_en;
        if (sts.byte_ready) begin
          if (idx_last) begin
            state_nxt = after_lit;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = idx_inc;
            idx_nxt    = idx_inc;
          end
        end
      end
      S_POST: begin
        cmd.byte_valid = 1'b1;
        cmd.byte_sel   = zrle_pkg::SEL_POST;
        cmd.byte_last  = 1'b1;
        if (sts.byte_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* tb/sv/tb_zero_run_length_encoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_zero_run_length_encoder_unit: self-checking bench for the zero RLE unit
// Drives raw bytes through the input channel and checks every code group
// against an in-bench encoder or a typed group of the directed table of typical
// and corner streams, then random literal, zero-run and noise segments, with random
// idling on both channels and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_zero_run_length_encoder_unit;

  localparam int MAX_LITERAL  = 128;
  localparam int MAX_ZERO_RUN = 129;
  localparam int IDLE_PCT     = 23;
  localparam int RAND_ITEMS   = 8;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_AT      = 20;
  localparam int CALM_END     = 220;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int N_ROWS       = 25;

  typedef logic [zrle_pkg::BYTE_W-1:0] code_byte_t;

  typedef struct packed {
    code_byte_t b0;
    code_byte_t b1;
    code_byte_t b2;
    code_byte_t b3;
    logic [2:0] cnt;
    logic       glast;
    logic       bend;
  } code_group_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_GROUP, ROW_ONE_GROUP} row_kind_t;

  typedef struct {
    code_byte_t  raw;
    logic        last;
    row_kind_t   kind;
    code_group_t grp;
  } stim_row_t;

  localparam code_group_t NO_GRP = '0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{8'hAB, 1'b1, ROW_ONE_GROUP, '{8'h00, 8'hAB, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{8'h00, 1'b1, ROW_ONE_GROUP, '{8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{8'h00, 1'b0, ROW_NO_GROUP,  NO_GRP},
    '{8'h00, 1'b1, ROW_ONE_GROUP, '{8'hFF, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 1'b1}},
    '{8'hFF, 1'b1, ROW_ONE_GROUP, '{8'h00, 8'hFF, 8'h00, 8'h00, 3'd2, 1'b1, 1'b1}},
    '{8'h01, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h05, 1'b1, ROW_PREDICT,   NO_GRP},
    '{8'h10, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b1, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h7F, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h80, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h55, 1'b1, ROW_PREDICT,   NO_GRP},
    '{8'h00, 1'b0, ROW_NO_GROUP,  NO_GRP},
    '{8'h00, 1'b0, ROW_NO_GROUP,  NO_GRP},
    '{8'h00, 1'b0, ROW_NO_GROUP,  NO_GRP},
    '{8'h00, 1'b1, ROW_ONE_GROUP, '{8'hFD, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 1'b1}},
    '{8'h12, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h34, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h56, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h78, 1'b0, ROW_PREDICT,   NO_GRP},
    '{8'h9A, 1'b1, ROW_PREDICT,   NO_GRP}
  };

  logic clk;
  logic rst_n;

  zrle_in_if  in_ch ();
  zrle_out_if out_ch ();

  zero_run_length_encoder_unit #(
    .MAX_LITERAL  (MAX_LITERAL),
    .MAX_ZERO_RUN (MAX_ZERO_RUN)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_byte_t  lit_store [MAX_LITERAL];
  int unsigned lit_len   = 0;
  int unsigned run_len   = 0;
  bit          prev_zero = 1'b0;

  code_byte_t  pending_codes [$];
  code_group_t item_groups [$];
  code_group_t expected_groups [$];

  int err_count  = 0;
  int cycle_cnt  = 0;
  int rx_cycle   = 0;
  bit burst_mode = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic void emit_literal_packet(input int unsigned n);
    int unsigned i;
    if (n != 0) begin
      pending_codes.push_back(code_byte_t'(n - 1));
      for (i = 0; i < n; i++) pending_codes.push_back(lit_store[i % MAX_LITERAL]);
    end
  endfunction

  function automatic void emit_run_packet();
    if (run_len != 0) begin
      pending_codes.push_back(code_byte_t'(1 - run_len));
      run_len = 0;
    end
  endfunction

  function automatic void absorb_byte(input code_byte_t b);
    if (b == 0 && prev_zero && lit_len >= 1) begin
      emit_literal_packet(lit_len - 1);
      lit_len   = 0;
      prev_zero = 1'b0;
      run_len   = 2;
      if (run_len >= MAX_ZERO_RUN) emit_run_packet();
    end else begin
      lit_store[lit_len % MAX_LITERAL] = b;
      lit_len++;
      prev_zero = (b == 0);
      if (lit_len >= MAX_LITERAL) begin
        emit_literal_packet(lit_len);
        lit_len   = 0;
        prev_zero = 1'b0;
      end
    end
  endfunction

  // advance the encoder state by one byte and pack its code bytes into groups
  function automatic void encode_byte(input code_byte_t b, input logic last);
    int          n;
    int          ng;
    int          cnt;
    int          i;
    int          k;
    code_byte_t  q [4];
    code_group_t g;
    pending_codes.delete();
    item_groups.delete();
    if (run_len > 0) begin
      if (b == 0) begin
        run_len++;
        if (run_len >= MAX_ZERO_RUN) emit_run_packet();
      end else begin
        emit_run_packet();
        absorb_byte(b);
      end
    end else begin
      absorb_byte(b);
    end
    if (last) begin
      emit_run_packet();
      emit_literal_packet(lit_len);
      lit_len   = 0;
      prev_zero = 1'b0;
      run_len   = 0;
    end
    n  = pending_codes.size();
    ng = (n + 3) / 4;
    for (i = 0; i < ng; i++) begin
      cnt = (n - 4 * i > 4) ? 4 : n - 4 * i;
      for (k = 0; k < 4; k++) q[k] = (k < cnt) ? pending_codes[4 * i + k] : '0;
      g = '{q[0], q[1], q[2], q[3], cnt[2:0], (i == ng - 1), (i == ng - 1) && last};
      item_groups.push_back(g);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0d] mismatch %s: got 0x%0h, want 0x%0h", cycle_cnt, what, got, want);
    err_count++;
  endtask

  task automatic send_byte(input code_byte_t b, input logic last, input row_kind_t kind,
                           input code_group_t typed);
    if (!burst_mode) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_byte   <= b;
    in_ch.block_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    encode_byte(b, last);
    case (kind)
      ROW_PREDICT: begin
        foreach (item_groups[i]) expected_groups.push_back(item_groups[i]);
      end
      ROW_ONE_GROUP: begin
        expected_groups.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  // hold off once for a long stretch, stay ready for another, idle at random elsewhere
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) rx_cycle++;
      if (!rst_n || (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_CYCLES)) begin
        out_ch.ready <= 1'b0;
      end else if (rx_cycle >= CALM_AT && rx_cycle < CALM_END) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : group_check
    code_group_t got;
    code_group_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.code_byte0, out_ch.code_byte1, out_ch.code_byte2, out_ch.code_byte3,
              out_ch.byte_count, out_ch.group_last, out_ch.block_end};
      if (expected_groups.size() == 0) begin
        report_mismatch("unexpected group", int'(got), 0);
      end else begin
        want = expected_groups.pop_front();
        if (got.b0 != want.b0) report_mismatch("code_byte0", int'(got.b0), int'(want.b0));
        if (got.b1 != want.b1) report_mismatch("code_byte1", int'(got.b1), int'(want.b1));
        if (got.b2 != want.b2) report_mismatch("code_byte2", int'(got.b2), int'(want.b2));
        if (got.b3 != want.b3) report_mismatch("code_byte3", int'(got.b3), int'(want.b3));
        if (got.cnt != want.cnt) begin
          report_mismatch("byte_count", int'(got.cnt), int'(want.cnt));
        end
        if (got.glast != want.glast) begin
          report_mismatch("group_last", int'(got.glast), int'(want.glast));
        end
        if (got.bend != want.bend) begin
          report_mismatch("block_end", int'(got.bend), int'(want.bend));
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("[%0d] timeout with %0d groups outstanding", cycle_cnt, expected_groups.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int         n_rand;
    int         seg_len;
    int         zero_pct;
    int         kind;
    code_byte_t b;
    logic       last;
    n_rand           = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.raw_byte   = '0;
    in_ch.block_last = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_byte(dir_rows[r].raw, dir_rows[r].last, dir_rows[r].kind,
                                    dir_rows[r].grp);

    // full literal, offered back to back
    burst_mode = 1'b1;
    repeat (130) send_byte(code_byte_t'($urandom_range(1, 255)), 1'b0, ROW_PREDICT, NO_GRP);
    burst_mode = 1'b0;
    send_byte(8'h3C, 1'b1, ROW_PREDICT, NO_GRP);

    while (n_rand < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        seg_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 135)
                                              : $urandom_range(1, 12);
        zero_pct = 15;
      end else if (kind < 8) begin
        seg_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 135)
                                              : $urandom_range(1, 6);
        zero_pct = 100;
      end else begin
        seg_len  = $urandom_range(1, 4);
        zero_pct = -1;
      end
      if (seg_len > RAND_ITEMS - n_rand) seg_len = RAND_ITEMS - n_rand;
      repeat (seg_len) begin
        if (zero_pct < 0) b = code_byte_t'($urandom_range(0, 255));
        else if ($urandom_range(0, 99) < zero_pct) b = '0;
        else b = code_byte_t'($urandom_range(1, 255));
        last = ($urandom_range(0, 19) == 0);
        send_byte(b, last, ROW_PREDICT, NO_GRP);
        n_rand++;
      end
    end
    send_byte(code_byte_t'($urandom_range(0, 255)), 1'b1, ROW_PREDICT, NO_GRP);
    in_ch.valid <= 1'b0;

    while (expected_groups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/zrle_pkg.sv
rtl/zrle_if.sv
rtl/zrle_ram.sv
rtl/zrle_packer.sv
rtl/zrle_dp.sv
rtl/zrle_ctrl.sv
rtl/zero_run_length_encoder_unit.sv
tb/sv/tb_zero_run_length_encoder_unit.sv
